@@ sv/ukwc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants, half-width table and UTF-8 encoding function of the UTF-8 kana width converter.
package ukwc_pkg;

    // conversion register codes
    localparam logic [1:0] MODE_HIRA  = 2'd0;
    localparam logic [1:0] MODE_HALF  = 2'd1;
    localparam logic [1:0] MODE_BOTH  = 2'd2;
    localparam logic [1:0] MODE_ASCII = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one code point handed from the decoder to the encoder
    typedef struct packed {
        logic [20:0] cp;
        logic        raw;   // cp[7:0] goes out as one byte, no encoding
        logic        last;  // last code point caused by its input byte
    } t_qent;

    typedef struct packed {
        logic [31:0] bytes; // first byte in [7:0]
        logic [2:0]  len;
    } t_enc;

    // half-width form of U+30A1..U+30F6: low byte of U+FFxx,
    // bit 8 voiced mark follows, bit 9 semi-voiced mark follows
    localparam logic [9:0] HALF_TAB [0:85] = '{
        10'h067, 10'h071, 10'h068, 10'h072, 10'h069, 10'h073, 10'h06A, 10'h074,
        10'h06B, 10'h075, 10'h076, 10'h176, 10'h077, 10'h177, 10'h078, 10'h178,
        10'h079, 10'h179, 10'h07A, 10'h17A, 10'h07B, 10'h17B, 10'h07C, 10'h17C,
        10'h07D, 10'h17D, 10'h07E, 10'h17E, 10'h07F, 10'h17F, 10'h080, 10'h180,
        10'h081, 10'h181, 10'h06F, 10'h082, 10'h182, 10'h083, 10'h183, 10'h084,
        10'h184, 10'h085, 10'h086, 10'h087, 10'h088, 10'h089, 10'h08A, 10'h18A,
        10'h28A, 10'h08B, 10'h18B, 10'h28B, 10'h08C, 10'h18C, 10'h28C, 10'h08D,
        10'h18D, 10'h28D, 10'h08E, 10'h18E, 10'h28E, 10'h08F, 10'h090, 10'h091,
        10'h092, 10'h093, 10'h06C, 10'h094, 10'h06D, 10'h095, 10'h06E, 10'h096,
        10'h097, 10'h098, 10'h099, 10'h09A, 10'h09B, 10'h09C, 10'h09C, 10'h072,
        10'h074, 10'h066, 10'h09D, 10'h173, 10'h076, 10'h079
    };

    // shortest UTF-8 form of a code point
    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp <= 21'h00007F) begin
            e.bytes[7:0] = {1'b0, cp[6:0]};
            e.len        = 3'd1;
        end else if (cp <= 21'h0007FF) begin
            e.bytes[7:0]  = {3'b110, cp[10:6]};
            e.bytes[15:8] = {2'b10, cp[5:0]};
            e.len         = 3'd2;
        end else if (cp <= 21'h00FFFF) begin
            e.bytes[7:0]   = {4'b1110, cp[15:12]};
            e.bytes[15:8]  = {2'b10, cp[11:6]};
            e.bytes[23:16] = {2'b10, cp[5:0]};
            e.len          = 3'd3;
        end else begin
            e.bytes[7:0]   = {5'b11110, cp[20:18]};
            e.bytes[15:8]  = {2'b10, cp[17:12]};
            e.bytes[23:16] = {2'b10, cp[11:6]};
            e.bytes[31:24] = {2'b10, cp[5:0]};
            e.len          = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ sv/utf8_kana_width_converter.sv @@
`timescale 1ns / 1ps
// UTF-8 kana width converter: one input byte per transfer in, converted UTF-8 bytes out.
// An input byte is taken every cycle while the four-entry code point queue has room;
// each byte yields zero to six output bytes, and the output side sends one byte per
// cycle while m_tready is high, so input follows the output byte count: one output byte
// per input byte for plain text, two for a three-byte kana that becomes a voiced
// half-width pair. A truncated sequence at end of text that re-decodes into two
// characters holds the input until both are queued. Write the mode register only while
// the block is idle; it is not enforced. A write drops any partly received sequence.
module utf8_kana_width_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,  // conversion
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_byte
    input  logic       s_tlast,      // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast       // last_of_item
);
    import ukwc_pkg::*;

    logic [1:0] r_mode;
    logic       push, q_full, q_valid, pop;
    t_qent      push_ent, head_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HIRA;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    ukwc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_cfg_we (i_cfg_we),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_byte   (s_tdata),
        .i_eot    (s_tlast),
        .o_push   (push),
        .o_ent    (push_ent),
        .i_q_full (q_full)
    );

    ukwc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (head_ent),
        .i_pop   (pop)
    );

    ukwc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .i_ent     (head_ent),
        .o_tvalid  (m_tvalid),
        .i_tready  (m_tready),
        .o_tdata   (m_tdata),
        .o_tlast   (m_tlast)
    );

endmodule

@@ sv/ukwc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input bytes, decodes UTF-8 (full-width mapping in ASCII mode) and queues code points.
module ukwc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_mode,
    input  logic                 i_cfg_we,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_eot,
    output logic                 o_push,
    output ukwc_pkg::t_qent      o_ent,
    input  logic                 i_q_full
);
    import ukwc_pkg::*;

    logic [7:0]  r_held [3];
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_need, n_need;
    logic        r_pend, n_pend;
    logic [10:0] r_pend_cp, n_pend_cp;
    logic [7:0]  n_h0, n_h1, n_h2;

    logic        acc;
    logic        main_v, main_raw;
    logic [20:0] main_cp;
    logic        fl_v0, fl_v1;
    logic [10:0] fl_cp0, fl_cp1;
    logic        two_byte;

    assign o_ready = !r_pend && !i_q_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_cnt    = r_cnt;
        n_need   = r_need;
        n_h0     = r_held[0];
        n_h1     = r_held[1];
        n_h2     = r_held[2];
        main_v   = 1'b0;
        main_raw = 1'b0;
        main_cp  = '0;
        fl_v0    = 1'b0;
        fl_v1    = 1'b0;
        fl_cp0   = '0;
        fl_cp1   = '0;
        two_byte = 1'b0;

        if (i_mode == MODE_ASCII) begin
            main_v = 1'b1;
            if (i_byte == 8'h20) begin
                main_cp = 21'h003000;
            end else if (i_byte >= 8'h21 && i_byte <= 8'h7E) begin
                main_cp = 21'h00FEE0 + {13'b0, i_byte};
            end else begin
                main_cp  = {13'b0, i_byte};
                main_raw = 1'b1;
            end
        end else if (r_need == 2'd0) begin
            if (!i_byte[7]) begin
                main_v  = 1'b1;
                main_cp = {13'b0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_need = 2'd1;
                n_cnt  = 2'd1;
                n_h0   = i_byte;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_need = 2'd2;
                n_cnt  = 2'd1;
                n_h0   = i_byte;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_need = 2'd3;
                n_cnt  = 2'd1;
                n_h0   = i_byte;
            end
        end else begin
            n_need = r_need - 2'd1;
            if (n_need == 2'd0) begin
                main_v = 1'b1;
                case (r_cnt)
                    2'd1: main_cp = {10'b0, r_held[0][4:0], i_byte[5:0]};
                    2'd2: main_cp = {5'b0, r_held[0][3:0], r_held[1][5:0], i_byte[5:0]};
                    default: main_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0],
                                        i_byte[5:0]};
                endcase
                n_cnt = 2'd0;
            end else if (r_cnt != 2'd3) begin
                case (r_cnt)
                    2'd1:    n_h1 = i_byte;
                    2'd2:    n_h2 = i_byte;
                    default: n_h0 = r_held[0];
                endcase
                n_cnt = r_cnt + 2'd1;
            end
        end

        // open sequence at end of text: drop the lead, re-decode what follows
        if (i_mode != MODE_ASCII && i_eot && n_need != 2'd0) begin
            if (n_cnt >= 2'd2) begin
                if (!n_h1[7]) begin
                    fl_v0  = 1'b1;
                    fl_cp0 = {4'b0, n_h1[6:0]};
                end else if (n_h1[7:5] == 3'b110 && n_cnt == 2'd3) begin
                    fl_v0    = 1'b1;
                    fl_cp0   = {n_h1[4:0], n_h2[5:0]};
                    two_byte = 1'b1;
                end
            end
            if (n_cnt == 2'd3 && !two_byte && !n_h2[7]) begin
                fl_v1  = 1'b1;
                fl_cp1 = {4'b0, n_h2[6:0]};
            end
            n_need = 2'd0;
            n_cnt  = 2'd0;
        end
    end

    always_comb begin
        o_push    = 1'b0;
        o_ent     = '0;
        n_pend    = r_pend;
        n_pend_cp = r_pend_cp;
        if (r_pend) begin
            o_ent.cp   = {10'b0, r_pend_cp};
            o_ent.last = 1'b1;
            if (!i_q_full) begin
                o_push = 1'b1;
                n_pend = 1'b0;
            end
        end else if (acc) begin
            if (main_v) begin
                o_push     = 1'b1;
                o_ent.cp   = main_cp;
                o_ent.raw  = main_raw;
                o_ent.last = 1'b1;
            end else if (fl_v0) begin
                o_push     = 1'b1;
                o_ent.cp   = {10'b0, fl_cp0};
                o_ent.last = !fl_v1;
                if (fl_v1) begin
                    n_pend    = 1'b1;
                    n_pend_cp = fl_cp1;
                end
            end else if (fl_v1) begin
                o_push     = 1'b1;
                o_ent.cp   = {10'b0, fl_cp1};
                o_ent.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cnt  <= '0;
            r_need <= '0;
            r_pend <= 1'b0;
        end else begin
            if (acc) begin
                r_cnt  <= n_cnt;
                r_need <= n_need;
            end
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_held[0] <= n_h0;
            r_held[1] <= n_h1;
            r_held[2] <= n_h2;
        end
        r_pend_cp <= n_pend_cp;
    end

endmodule

@@ sv/ukwc_fifo.sv @@
`timescale 1ns / 1ps
// Short code point queue between decoder and encoder.
module ukwc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ukwc_pkg::t_qent i_ent,
    output logic            o_full,
    output logic            o_valid,
    output ukwc_pkg::t_qent o_ent,
    input  logic            i_pop
);
    import ukwc_pkg::*;

    t_qent          r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;
    logic           wr, rd;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) r_wptr <= r_wptr + 1'b1;
            if (rd) r_rptr <= r_rptr + 1'b1;
            if (wr && !rd)      r_count <= r_count + 1'b1;
            else if (!wr && rd) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wptr] <= i_ent;
    end

endmodule

@@ sv/ukwc_back.sv @@
`timescale 1ns / 1ps
// Back end: maps each code point for the mode and shifts its UTF-8 bytes, or its raw byte, out.
module ukwc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_mode,
    input  logic            i_q_valid,
    output logic            o_pop,
    input  ukwc_pkg::t_qent i_ent,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);
    import ukwc_pkg::*;

    logic [47:0] r_buf, ld_buf;
    logic [2:0]  r_cnt, ld_cnt;
    logic        r_last;
    logic        take;

    logic [20:0] kc, hcp, off;
    logic [9:0]  e;
    logic        mark;
    logic [7:0]  mark_byte;
    t_enc        enc;

    always_comb begin
        kc        = i_ent.cp;
        hcp       = kc;
        off       = '0;
        e         = '0;
        mark      = 1'b0;
        mark_byte = 8'h9E;
        if ((i_mode == MODE_HIRA || i_mode == MODE_BOTH) &&
            ((kc >= 21'h3041 && kc <= 21'h3096) || kc == 21'h309D || kc == 21'h309E)) begin
            kc = i_ent.cp + 21'h60;
        end
        hcp = kc;
        if (i_mode == MODE_HALF || i_mode == MODE_BOTH) begin
            case (kc)
                21'h3002: hcp = 21'h00FF61;
                21'h3001: hcp = 21'h00FF64;
                21'h30FB: hcp = 21'h00FF65;
                21'h30FC: hcp = 21'h00FF70;
                21'h300C: hcp = 21'h00FF62;
                21'h300D: hcp = 21'h00FF63;
                default: begin
                    if (kc >= 21'h30A1 && kc <= 21'h30F6) begin
                        off       = kc - 21'h30A1;
                        e         = HALF_TAB[off[6:0]];
                        hcp       = {13'h00FF, e[7:0]};
                        mark      = e[8] || e[9];
                        mark_byte = e[8] ? 8'h9E : 8'h9F;
                    end
                end
            endcase
        end
        enc = utf8_enc(hcp);
        if (i_ent.raw) begin
            ld_buf = {40'b0, i_ent.cp[7:0]};
            ld_cnt = 3'd1;
        end else if (mark) begin
            // half-width base is always three bytes; mark is EF BE 9E/9F
            ld_buf = {mark_byte, 8'hBE, 8'hEF, enc.bytes[23:0]};
            ld_cnt = 3'd6;
        end else begin
            ld_buf = {16'b0, enc.bytes};
            ld_cnt = enc.len;
        end
    end

    assign o_tvalid = (r_cnt != 3'd0);
    assign o_tdata  = r_buf[7:0];
    assign o_tlast  = r_last && (r_cnt == 3'd1);
    assign take     = o_tvalid && i_tready;
    assign o_pop    = i_q_valid && (r_cnt == 3'd0 || (r_cnt == 3'd1 && take));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_pop) begin
            r_cnt <= ld_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buf  <= ld_buf;
            r_last <= i_ent.last;
        end else if (take) begin
            r_buf <= {8'b0, r_buf[47:8]};
        end
    end

endmodule

@@ sv/ukwc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the UTF-8 kana width converter, bound to the top level.
module ukwc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_wdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import ukwc_pkg::*;

    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HIRA;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer withdrawn before acceptance");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    // in decoded modes an item never ends on a lead byte
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && r_mode != MODE_ASCII && m_tdata[7:6] == 2'b11
        |-> !m_tlast)
        else $error("item ends inside a multi-byte character");

endmodule

bind utf8_kana_width_converter ukwc_checker u_ukwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
);
